// ----- rtl/core/sdlr_pkg.sv -----
// Package with the shared constants, command and status types of the resampler.
package sdlr_pkg;

  // Fixed field widths of the channels and the configuration register.
  localparam int SAMPLE_W = 16;
  localparam int STEP_BITS = 18;
  localparam logic [STEP_BITS-1:0] STEP_RESET = 18'd48637;

  // Default fraction width of the phase accumulator.
  localparam int FRAC_BITS_DEF = 16;

  // A run never produces more results than this for one input frame.
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W = $clog2(MAX_RESULTS);

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_LOAD
  } sdlr_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept_prime;
    logic accept_skip;
    logic accept_run;
    logic calc;
    logic load;
  } sdlr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic primed;
    logic phase_ge_one;
    logic last;
  } sdlr_status_t;

endpackage

// ----- rtl/core/sdlr_if.sv -----
// Channel interfaces for the stereo input frames and the mono result samples.
interface sdlr_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [sdlr_pkg::SAMPLE_W-1:0] left_sample;
  logic signed [sdlr_pkg::SAMPLE_W-1:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

interface sdlr_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [sdlr_pkg::SAMPLE_W-1:0] out_sample;
  logic                                  last_of_run;

  modport source (output valid, output out_sample, output last_of_run, input ready);
  modport sink (input valid, input out_sample, input last_of_run, output ready);
endinterface

// ----- rtl/core/sdlr_ctrl.sv -----
// Controller state machine that sequences acceptance, interpolation and result hand-off.
module sdlr_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  input  sdlr_pkg::sdlr_status_t  status,
  output sdlr_pkg::sdlr_cmd_t     cmd
);

  sdlr_pkg::sdlr_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_free;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_r || out_ready;

  // Command decode.
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      sdlr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.accept_prime = in_valid && !status.primed;
        cmd.accept_skip = in_valid && status.primed && status.phase_ge_one;
        cmd.accept_run = in_valid && status.primed && !status.phase_ge_one;
      end
      sdlr_pkg::ST_CALC: begin
        cmd.calc = 1'b1;
      end
      sdlr_pkg::ST_LOAD: begin
        cmd.load = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sdlr_pkg::ST_IDLE: begin
        if (in_valid && status.primed && !status.phase_ge_one) begin
          state_nxt = sdlr_pkg::ST_CALC;
        end
      end
      sdlr_pkg::ST_CALC: begin
        state_nxt = sdlr_pkg::ST_LOAD;
      end
      sdlr_pkg::ST_LOAD: begin
        if (out_free) begin
          state_nxt = status.last ? sdlr_pkg::ST_IDLE : sdlr_pkg::ST_CALC;
        end
      end
      default: begin
        state_nxt = sdlr_pkg::ST_IDLE;
      end
    endcase
  end

  // Output valid flag: set on a load, cleared when the transaction completes.
  always_comb begin
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sdlr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/core/sdlr_datapath.sv -----
// Datapath: downmix, phase accumulator, interpolation multiplier and output register.
module sdlr_datapath #(
  parameter int FRAC_BITS = sdlr_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic [sdlr_pkg::STEP_BITS-1:0]         cfg_wr_data,
  input  logic signed [sdlr_pkg::SAMPLE_W-1:0]   in_left,
  input  logic signed [sdlr_pkg::SAMPLE_W-1:0]   in_right,
  input  sdlr_pkg::sdlr_cmd_t                    cmd,
  output sdlr_pkg::sdlr_status_t                 status,
  output logic signed [sdlr_pkg::SAMPLE_W-1:0]   out_sample,
  output logic                                   out_last
);

  localparam int SW = sdlr_pkg::SAMPLE_W;
  localparam int SB = sdlr_pkg::STEP_BITS;
  localparam int ACC_W = ((FRAC_BITS > SB) ? FRAC_BITS : SB) + 2;
  localparam int PROD_W = FRAC_BITS + SW + 2;
  localparam logic [ACC_W-1:0] ONE = ACC_W'(1) << FRAC_BITS;
  localparam logic [PROD_W-1:0] BIAS = (PROD_W'(1) << FRAC_BITS) - PROD_W'(1);
  localparam logic [sdlr_pkg::CNT_W-1:0] CNT_LAST = sdlr_pkg::CNT_W'(sdlr_pkg::MAX_RESULTS - 1);

  logic [SB-1:0]                 step_r;
  logic [ACC_W-1:0]              phase_r;
  logic signed [SW-1:0]          prev_r;
  logic signed [SW-1:0]          cur_r;
  logic                          primed_r;
  logic [sdlr_pkg::CNT_W-1:0]    cnt_r;
  logic signed [PROD_W-1:0]      acc_r;
  logic signed [SW-1:0]          out_sample_r;
  logic                          out_last_r;

  logic signed [SW:0]            mix_sum;
  logic signed [SW:0]            mix_adj;
  logic signed [SW-1:0]          mono;
  logic [ACC_W-1:0]              phase_sum;
  logic signed [SW:0]            diff;
  logic signed [FRAC_BITS:0]     frac;
  logic signed [PROD_W-1:0]      base;
  logic signed [PROD_W-1:0]      acc_nxt;
  logic [PROD_W-1:0]             rounded;
  logic                          last;

  // Downmix: average of left and right, truncated toward zero.
  assign mix_sum = {in_left[SW-1], in_left} + {in_right[SW-1], in_right};
  assign mix_adj = mix_sum + {{SW{1'b0}}, mix_sum[SW]};
  assign mono = mix_adj[SW:1];

  // Phase after this step and the end-of-run decision.
  assign phase_sum = phase_r + {{(ACC_W-SB){1'b0}}, step_r};
  assign last = (phase_sum >= ONE) || (cnt_r == CNT_LAST);

  // Interpolation as prev*one + (cur-prev)*phase, one multiplier.
  assign diff = {cur_r[SW-1], cur_r} - {prev_r[SW-1], prev_r};
  assign frac = $signed({1'b0, phase_r[FRAC_BITS-1:0]});
  assign base = $signed({{2{prev_r[SW-1]}}, prev_r, {FRAC_BITS{1'b0}}});
  assign acc_nxt = base + diff * frac;

  // Shift right with truncation toward zero.
  assign rounded = acc_r + (acc_r[PROD_W-1] ? BIAS : {PROD_W{1'b0}});

  // Configuration register and control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= sdlr_pkg::STEP_RESET;
      phase_r <= '0;
      prev_r <= '0;
      primed_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        step_r <= cfg_wr_data;
      end
      if (cmd.accept_prime) begin
        prev_r <= mono;
        primed_r <= 1'b1;
      end
      if (cmd.accept_skip) begin
        prev_r <= mono;
        phase_r <= phase_r - ONE;
      end
      if (cmd.load) begin
        if (!last) begin
          phase_r <= phase_sum;
        end else begin
          phase_r <= (phase_sum >= ONE) ? (phase_sum - ONE) : '0;
          prev_r <= cur_r;
        end
      end
    end
  end

  // Run payload: current sample, result count, product and output register.
  always_ff @(posedge clk) begin
    if (cmd.accept_run) begin
      cur_r <= mono;
      cnt_r <= '0;
    end
    if (cmd.calc) begin
      acc_r <= acc_nxt;
    end
    if (cmd.load) begin
      out_sample_r <= rounded[FRAC_BITS+SW-1:FRAC_BITS];
      out_last_r <= last;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign status.primed = primed_r;
  assign status.phase_ge_one = (phase_r >= ONE);
  assign status.last = last;
  assign out_sample = out_sample_r;
  assign out_last = out_last_r;

endmodule

// ----- rtl/core/stereo_downmix_linear_resampler.sv -----
// Top level of the stereo downmix and linear-interpolation resampler.
//
//  Channel | Direction | Payload                        | Transaction
//  in_ch   | sink      | left_sample, right_sample      | valid && ready
//  out_ch  | source    | out_sample, last_of_run        | valid && ready
//  cfg_    | write     | cfg_wr_data (phase_step)       | cfg_wr_en
//
// A frame that produces no result (the first one, or phase already at or
// above one) is taken in the idle state. A frame with results then runs a
// multiply step and an output-register load for each of its results.
// in_ch is ready only while no run is in progress; out_ch stalls hold the
// run at its load step. Reset is synchronous: step returns to 48637, phase,
// previous sample and priming clear.
module stereo_downmix_linear_resampler #(
  parameter int FRAC_BITS = sdlr_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  sdlr_in_if.sink                        in_ch,
  sdlr_out_if.source                     out_ch,
  input  logic                           cfg_wr_en,
  input  logic [sdlr_pkg::STEP_BITS-1:0] cfg_wr_data
);

  sdlr_pkg::sdlr_cmd_t    cmd;
  sdlr_pkg::sdlr_status_t status;

  // Sequencing.
  sdlr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic and storage.
  sdlr_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_left     (in_ch.left_sample),
    .in_right    (in_ch.right_sample),
    .cmd         (cmd),
    .status      (status),
    .out_sample  (out_ch.out_sample),
    .out_last    (out_ch.last_of_run)
  );

endmodule
